@@ design/ilp_pkg.sv @@
// Package for the integer literal parser: widths, character codes and the character class type.
package ilp_pkg;

   // Width of the result word on the port; the accumulator width is a parameter.
   localparam int OUT_WIDTH           = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int CHAR_WIDTH          = 8;

   // Character codes that steer the parse.
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] LETTER_BASE  = 8'h0a;

   // Decoded view of one character, passed from the classifier to the parse core.
   typedef struct packed {
      logic       blank;
      logic       plus;
      logic       minus;
      logic       zero;
      logic       hex_x;
      logic       digit_ok;
      logic [3:0] digit;
   } char_class_type;

endpackage

@@ design/ilp_if.sv @@
// Handshake interfaces for the character input channel and the result channel.
interface ilp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       start_new;

   modport source (output valid, output char_in, output start_new, input ready);
   modport sink   (input valid, input char_in, input start_new, output ready);
endinterface

interface ilp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ design/ilp_classify.sv @@
// Character classifier: decodes one ASCII byte into whitespace, sign, prefix and digit flags.
module ilp_classify (
   input  logic [ilp_pkg::CHAR_WIDTH-1:0] char_in,
   output ilp_pkg::char_class_type        cls
);
   import ilp_pkg::*;

   logic [CHAR_WIDTH-1:0] dec_val;
   logic [CHAR_WIDTH-1:0] low_val;
   logic [CHAR_WIDTH-1:0] up_val;

   // Candidate digit values for each digit range.
   assign dec_val = char_in - CHAR_ZERO;
   assign low_val = char_in - CHAR_LOWER_A + LETTER_BASE;
   assign up_val  = char_in - CHAR_UPPER_A + LETTER_BASE;

   // Flag decode and digit selection.
   always_comb begin
      cls.blank = (char_in == CHAR_SPACE) || (char_in inside {[CHAR_TAB:CHAR_CR]});
      cls.plus  = (char_in == CHAR_PLUS);
      cls.minus = (char_in == CHAR_MINUS);
      cls.zero  = (char_in == CHAR_ZERO);
      cls.hex_x = (char_in == CHAR_LOWER_X) || (char_in == CHAR_UPPER_X);
      cls.digit_ok = 1'b1;
      if (char_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
         cls.digit = dec_val[3:0];
      end else if (char_in inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         cls.digit = low_val[3:0];
      end else if (char_in inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         cls.digit = up_val[3:0];
      end else begin
         cls.digit_ok = 1'b0;
         cls.digit    = 4'd0;
      end
   end

endmodule

@@ design/ilp_core.sv @@
// Parse core: holds phase, radix, sign and accumulator, and steps them by one character.
module ilp_core #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           start_new,
   input  ilp_pkg::char_class_type        cls,
   output logic                           emit,
   output logic [ilp_pkg::OUT_WIDTH-1:0]  value
);
   import ilp_pkg::*;

   typedef enum logic [2:0] {
      PH_SPACE, PH_PLUS, PH_MINUS, PH_ZERO, PH_X, PH_DIGITS, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC, RADIX_OCT, RADIX_HEX
   } radix_type;

   phase_type              phase_ff, phase_in;
   radix_type              radix_ff, radix_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;

   phase_type              ph_start;
   radix_type              radix_start;
   logic                   neg_start;
   logic [VALUE_WIDTH-1:0] acc_start;
   logic [VALUE_WIDTH-1:0] acc_scaled;
   logic                   consumed;
   logic signed [VALUE_WIDTH-1:0] result_s;

   // A start flag clears the parse state before this character is looked at.
   assign ph_start    = start_new ? PH_SPACE  : phase_ff;
   assign radix_start = start_new ? RADIX_DEC : radix_ff;
   assign neg_start   = start_new ? 1'b0      : neg_ff;
   assign acc_start   = start_new ? '0        : acc_ff;

   // Multiply by the radix with shifts; decimal is times eight plus times two.
   always_comb begin
      case (radix_start)
         RADIX_HEX: acc_scaled = {acc_start[VALUE_WIDTH-5:0], 4'b0000};
         RADIX_OCT: acc_scaled = {acc_start[VALUE_WIDTH-4:0], 3'b000};
         default:   acc_scaled = {acc_start[VALUE_WIDTH-4:0], 3'b000}
                               + {acc_start[VALUE_WIDTH-2:0], 1'b0};
      endcase
   end

   // Walk the prefix phases; a character falls through each phase it does not use.
   always_comb begin
      phase_in = ph_start;
      radix_in = radix_start;
      neg_in   = neg_start;
      acc_in   = acc_start;
      emit     = 1'b0;
      consumed = (ph_start == PH_DONE);

      if (!consumed && phase_in == PH_SPACE) begin
         if (cls.blank) begin
            consumed = 1'b1;
         end else begin
            phase_in = PH_PLUS;
         end
      end
      if (!consumed && phase_in == PH_PLUS) begin
         phase_in = PH_MINUS;
         consumed = cls.plus;
      end
      if (!consumed && phase_in == PH_MINUS) begin
         phase_in = PH_ZERO;
         if (cls.minus) begin
            neg_in   = 1'b1;
            consumed = 1'b1;
         end
      end
      if (!consumed && phase_in == PH_ZERO) begin
         if (cls.zero) begin
            radix_in = RADIX_OCT;
            phase_in = PH_X;
            consumed = 1'b1;
         end else begin
            phase_in = PH_DIGITS;
         end
      end
      if (!consumed && phase_in == PH_X) begin
         phase_in = PH_DIGITS;
         if (cls.hex_x) begin
            radix_in = RADIX_HEX;
            consumed = 1'b1;
         end
      end
      if (!consumed) begin
         if (cls.digit_ok) begin
            acc_in = acc_scaled + VALUE_WIDTH'(cls.digit);
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end
   end

   // Apply the sign and widen to the port word with sign extension.
   assign result_s = neg_start ? -$signed(acc_start) : $signed(acc_start);
   assign value    = OUT_WIDTH'(result_s);

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         radix_ff <= RADIX_DEC;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

@@ design/integer_literal_parser.sv @@
// Top level of the integer literal parser: input register, parse core and result register.
//
//   channel   direction   word                        notes
//   req_ch    in          char_in[7:0], start_new     one character per word
//   rsp_ch    out         value[63:0] signed          one word per finished literal
//
// One character is taken per cycle while the input register is empty or moving on; a character
// waits in the input register, and a terminator's result is then loaded into the result register.
// The accumulator update is a shift-add of the radix, done in the single parse stage.
// Reset is synchronous and leaves the parser waiting for a start flag.
// The input register moves on whenever the result register is empty or being read;
// while a result waits unread, one more character is still taken into the input register.
module integer_literal_parser #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ilp_req_if.sink      req_ch,
   ilp_rsp_if.source    rsp_ch
);
   import ilp_pkg::*;

   logic                  in_valid_ff;
   logic [CHAR_WIDTH-1:0] in_char_ff;
   logic                  in_start_ff;
   logic                  out_valid_ff;
   logic [OUT_WIDTH-1:0]  out_value_ff;

   logic                  advance;
   logic                  emit;
   logic [OUT_WIDTH-1:0]  value;
   char_class_type        cls;

   // The parse stage fires when its word is present and the result slot is free.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   ilp_classify u_classify (
      .char_in (in_char_ff),
      .cls     (cls)
   );

   ilp_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .start_new (in_start_ff),
      .cls       (cls),
      .emit      (emit),
      .value     (value)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_char_ff  <= req_ch.char_in;
         in_start_ff <= req_ch.start_new;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_value_ff <= value;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.value = out_value_ff;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the integer literal parser: character stream in, parsed values out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ilp_pkg::*;

   localparam int ACC_WIDTH   = VALUE_WIDTH_DEFAULT;
   localparam int CHAR_TARGET = 1500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 20;

   // Character codes the package does not name.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_Z     = 8'h7a;

   typedef enum logic [2:0] {
      SCAN_BLANK, SCAN_PLUS, SCAN_MINUS, SCAN_ZERO, SCAN_X, SCAN_DIGITS, SCAN_DONE
   } scan_phase_type;

   typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_type;

   // Tracks the parse of every accepted character and holds the values still to come.
   class literal_tracker_type;
      scan_phase_type     phase;
      logic [63:0]        acc;
      radix_type          radix;
      bit                 negative;
      logic signed [63:0] pending_values[$];
      int                 errors;

      function new();
         phase    = SCAN_DONE;
         acc      = '0;
         radix    = RADIX_DEC;
         negative = 1'b0;
         errors   = 0;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      // Digit value of c, or -1 when c is not a digit in any radix.
      function int digit_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A + LETTER_BASE);
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A + LETTER_BASE);
         return -1;
      endfunction

      // Advances the parse by one accepted word; a finished literal queues its value.
      function void note_char(logic [7:0] c, bit start);
         logic [63:0] mask;
         logic [63:0] v;
         logic [63:0] mult;
         int          d;
         mask = {64{1'b1}} >> (64 - ACC_WIDTH);
         if (start) begin
            phase    = SCAN_BLANK;
            acc      = '0;
            radix    = RADIX_DEC;
            negative = 1'b0;
         end
         if (phase == SCAN_DONE) return;
         if (phase == SCAN_BLANK) begin
            if (is_blank(c)) return;
            phase = SCAN_PLUS;
         end
         if (phase == SCAN_PLUS) begin
            phase = SCAN_MINUS;
            if (c == CHAR_PLUS) return;
         end
         if (phase == SCAN_MINUS) begin
            phase = SCAN_ZERO;
            if (c == CHAR_MINUS) begin
               negative = 1'b1;
               return;
            end
         end
         if (phase == SCAN_ZERO) begin
            if (c == CHAR_ZERO) begin
               radix = RADIX_OCT;
               phase = SCAN_X;
               return;
            end
            phase = SCAN_DIGITS;
         end
         if (phase == SCAN_X) begin
            phase = SCAN_DIGITS;
            if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
               radix = RADIX_HEX;
               return;
            end
         end
         d = digit_value(c);
         if (d >= 0) begin
            case (radix)
               RADIX_HEX: mult = 64'd16;
               RADIX_OCT: mult = 64'd8;
               default:   mult = 64'd10;
            endcase
            acc = (acc * mult + 64'(d)) & mask;
            return;
         end
         // Terminator: emit the value, negated if a minus sign was seen, sign-extended.
         v = negative ? ((64'd0 - acc) & mask) : acc;
         v = v << (64 - ACC_WIDTH);
         pending_values.push_back($signed(v) >>> (64 - ACC_WIDTH));
         phase = SCAN_DONE;
      endfunction

      function void check_value(logic signed [63:0] got);
         logic signed [63:0] want;
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected value: expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = pending_values.pop_front();
         if (got !== want) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction

      function int pending();
         return pending_values.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   chars_sent;
   bit   no_gaps;

   ilp_req_if req();
   ilp_rsp_if rsp();

   literal_tracker_type tracker;

   integer_literal_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: a hang anywhere ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // No gap half of the time, else mostly short gaps and a few long ones.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one word and waits for it to be taken.
   task automatic send_word(input logic [7:0] c, input bit s);
      req.valid     <= 1'b1;
      req.char_in   <= c;
      req.start_new <= s;
      do @(posedge clock); while (!req.ready);
      tracker.note_char(c, s);
      chars_sent++;
   endtask

   task automatic sender_gap();
      int n;
      n = no_gaps ? 0 : pick_gap();
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit first_start);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], first_start && i == 0);
         sender_gap();
      end
   endtask

   task automatic send_one(input logic [7:0] c, input bit s);
      send_word(c, s);
      sender_gap();
   endtask

   // Builds one literal with random prefix and digits, plus occasional noise.
   task automatic send_literal();
      logic [7:0] text[$];
      bit         starts[$];
      logic [7:0] blanks[6];
      logic [7:0] c;
      string      hex_set;
      string      any_set;
      int         ndig;
      int         r;
      radix_type  rad;
      blanks  = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
      hex_set = "0123456789abcdefABCDEF";
      any_set = hex_set;
      rad     = RADIX_DEC;
      if ($urandom_range(0, 1))
         repeat ($urandom_range(1, 3)) text.push_back(blanks[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) < 3) text.push_back(CHAR_PLUS);
      if ($urandom_range(0, 9) < 4) text.push_back(CHAR_MINUS);
      r = $urandom_range(0, 9);
      if (r >= 4) begin
         text.push_back(CHAR_ZERO);
         rad = RADIX_OCT;
         if (r >= 6) begin
            text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            rad = RADIX_HEX;
         end
      end
      ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      repeat (ndig) begin
         if ($urandom_range(0, 4) == 0)
            c = any_set[$urandom_range(0, 21)];
         else if (rad == RADIX_HEX)
            c = hex_set[$urandom_range(0, 21)];
         else if (rad == RADIX_OCT)
            c = hex_set[$urandom_range(0, 7)];
         else
            c = hex_set[$urandom_range(0, 9)];
         text.push_back(c);
      end
      // Terminator, sometimes a random byte that may not end the literal at all.
      case ($urandom_range(0, 9))
         0:       c = CHAR_NUL;
         1:       c = CHAR_SPACE;
         2:       c = CHAR_COMMA;
         3:       c = CHAR_SEMI;
         4:       c = CHAR_G;
         5:       c = CHAR_PLUS;
         6:       c = CHAR_MINUS;
         7:       c = 8'($urandom_range(128, 255));
         default: c = 8'($urandom_range(0, 255));
      endcase
      text.push_back(c);
      foreach (text[i]) starts.push_back(i == 0);
      // Restart in the middle of the literal.
      if (text.size() > 1 && $urandom_range(0, 9) == 0)
         starts[$urandom_range(1, text.size() - 1)] = 1'b1;
      // Trailing bytes while the parser is finished.
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 3)) begin
            text.push_back(8'($urandom_range(0, 255)));
            starts.push_back(1'b0);
         end
      no_gaps = ($urandom_range(0, 4) == 0);
      foreach (text[i]) send_one(text[i], starts[i]);
   endtask

   // Receiver: random stalls, and one long hold so the parser backs up into its input.
   task automatic drain_values();
      int n;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      forever begin
         n = pick_gap();
         if (!held && taken == 30) begin
            n    = LONG_HOLD;
            held = 1'b1;
         end
         if (n > 0) begin
            rsp.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         tracker.check_value(rsp.value);
         taken++;
      end
   endtask

   initial begin
      tracker       = new();
      chars_sent    = 0;
      no_gaps       = 1'b0;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.char_in   <= CHAR_NUL;
      req.start_new <= 1'b0;
      rsp.ready     <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_values();
      join_none

      // Directed: ignored byte before any start, every blank, sign order, prefixes.
      send_one(CHAR_Z, 1'b0);
      send_one(CHAR_TAB, 1'b1);
      send_one(CHAR_LF, 1'b0);
      send_one(CHAR_VT, 1'b0);
      send_one(CHAR_FF, 1'b0);
      send_one(CHAR_CR, 1'b0);
      send_text(" 9", 1'b0);
      send_one(CHAR_NUL, 1'b0);
      send_text("+-0xF", 1'b1);
      send_one(8'hff, 1'b0);
      send_text("-+", 1'b1);
      send_text("079A;", 1'b1);
      send_text("0Xa,", 1'b1);
      send_text("12", 1'b1);
      send_text("3 ", 1'b1);
      send_one(CHAR_NUL, 1'b1);

      // Random literals, mostly well formed, some pure noise.
      while (chars_sent < CHAR_TARGET) begin
         if ($urandom_range(0, 19) == 0) begin
            no_gaps = 1'b0;
            repeat ($urandom_range(1, 8))
               send_one(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            send_literal();
         end
      end
      req.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
